// ===== rtl/rc4_pkg.sv =====
// Shared constants, controller states and command/status types for the RC4 engine.
`default_nettype none

package rc4_pkg;

    localparam int unsigned BYTE_W              = 8;
    localparam int unsigned PERM_SIZE           = 256;
    localparam int unsigned KEY_STORE_DEPTH_DEF = 256;

    localparam logic [BYTE_W-1:0] PERM_LAST = 8'hFF;

    localparam logic FUNC_KEY_LOAD  = 1'b0;
    localparam logic FUNC_KEYSTREAM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCH_RD,
        ST_SCH_B,
        ST_SCH_WN,
        ST_SCH_WB,
        ST_KS_J,
        ST_KS_WA,
        ST_KS_WJ,
        ST_KS_RS,
        ST_KS_OUT
    } t_state;

    typedef struct packed {
        logic key_load;
        logic sched_start;
        logic sch_rd;
        logic sch_b;
        logic sch_wr_n;
        logic sch_wr_b;
        logic ks_rd_a;
        logic ks_rd_j;
        logic ks_wr_a;
        logic ks_wr_j;
        logic ks_rd_s;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sched_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/rc4_ctrl.sv =====
// Sequencing state machine for key loading, key schedule and keystream steps.
`default_nettype none

module rc4_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_func,
    input  wire logic             i_key_last,
    output logic                  o_ready,
    output rc4_pkg::t_dp_cmd      o_cmd,
    input  wire rc4_pkg::t_dp_sts i_sts
);

    rc4_pkg::t_state r_state;
    rc4_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rc4_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rc4_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_func == rc4_pkg::FUNC_KEYSTREAM) begin
                        n_state = rc4_pkg::ST_KS_J;
                    end else if (i_key_last) begin
                        n_state = rc4_pkg::ST_SCH_RD;
                    end
                end
            end
            rc4_pkg::ST_SCH_RD: n_state = rc4_pkg::ST_SCH_B;
            rc4_pkg::ST_SCH_B:  n_state = rc4_pkg::ST_SCH_WN;
            rc4_pkg::ST_SCH_WN: n_state = rc4_pkg::ST_SCH_WB;
            rc4_pkg::ST_SCH_WB: begin
                n_state = i_sts.sched_last ? rc4_pkg::ST_IDLE : rc4_pkg::ST_SCH_RD;
            end
            rc4_pkg::ST_KS_J:   n_state = rc4_pkg::ST_KS_WA;
            rc4_pkg::ST_KS_WA:  n_state = rc4_pkg::ST_KS_WJ;
            rc4_pkg::ST_KS_WJ:  n_state = rc4_pkg::ST_KS_RS;
            rc4_pkg::ST_KS_RS:  n_state = rc4_pkg::ST_KS_OUT;
            rc4_pkg::ST_KS_OUT: begin
                if (i_sts.out_free) begin
                    n_state = rc4_pkg::ST_IDLE;
                end
            end
            default: n_state = rc4_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            rc4_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_func == rc4_pkg::FUNC_KEYSTREAM) begin
                        o_cmd.ks_rd_a = 1'b1;
                    end else begin
                        o_cmd.key_load    = 1'b1;
                        o_cmd.sched_start = i_key_last;
                    end
                end
            end
            rc4_pkg::ST_SCH_RD: o_cmd.sch_rd   = 1'b1;
            rc4_pkg::ST_SCH_B:  o_cmd.sch_b    = 1'b1;
            rc4_pkg::ST_SCH_WN: o_cmd.sch_wr_n = 1'b1;
            rc4_pkg::ST_SCH_WB: o_cmd.sch_wr_b = 1'b1;
            rc4_pkg::ST_KS_J:   o_cmd.ks_rd_j  = 1'b1;
            rc4_pkg::ST_KS_WA:  o_cmd.ks_wr_a  = 1'b1;
            rc4_pkg::ST_KS_WJ:  o_cmd.ks_wr_j  = 1'b1;
            rc4_pkg::ST_KS_RS:  o_cmd.ks_rd_s  = 1'b1;
            rc4_pkg::ST_KS_OUT: o_cmd.out_load = i_sts.out_free;
            default: begin
                o_cmd   = '0;
                o_ready = 1'b0;
            end
        endcase
    end

    // an accepted keystream request passes ST_KS_J, ST_KS_WA, ST_KS_WJ and ST_KS_RS to the result stage
    a_ks_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_func == rc4_pkg::FUNC_KEYSTREAM)
            |-> ##5 (r_state == rc4_pkg::ST_KS_OUT))
        else $error("keystream step did not reach result stage on time");

    a_sched_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc4_pkg::ST_SCH_WB && i_sts.sched_last) |=> (r_state == rc4_pkg::ST_IDLE))
        else $error("key schedule did not return to idle after last step");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (i_sts.out_free && r_state == rc4_pkg::ST_KS_OUT))
        else $error("result loaded while output register busy");

endmodule

`default_nettype wire

// ===== rtl/rc4_dp.sv =====
// Datapath: permutation memory with per-entry valid bits, key store, indices, result register.
`default_nettype none

module rc4_dp #(
    parameter int unsigned KEY_STORE_DEPTH = rc4_pkg::KEY_STORE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire rc4_pkg::t_dp_cmd           i_cmd,
    output rc4_pkg::t_dp_sts                o_sts,
    input  wire logic [rc4_pkg::BYTE_W-1:0] i_key_byte,
    output logic      [rc4_pkg::BYTE_W-1:0] o_keystream_byte,
    output logic                            o_valid,
    input  wire logic                       i_ready
);

    localparam int unsigned BW     = rc4_pkg::BYTE_W;
    localparam int unsigned KIDX_W = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
    localparam int unsigned KCNT_W = $clog2(KEY_STORE_DEPTH + 1);
    localparam logic [KCNT_W-1:0] KCNT_MAX = KCNT_W'(KEY_STORE_DEPTH);

    // storage
    logic [BW-1:0]                  r_perm [rc4_pkg::PERM_SIZE];
    logic [rc4_pkg::PERM_SIZE-1:0]  r_pvld;
    logic [BW-1:0]                  r_key_mem [KEY_STORE_DEPTH];

    logic [BW-1:0]     r_rd_data;
    logic              r_rd_vld;
    logic [BW-1:0]     r_rd_addr;
    logic [BW-1:0]     r_key_q;

    logic [BW-1:0]     r_idx_i;
    logic [BW-1:0]     r_idx_j;
    logic [BW-1:0]     r_sa;
    logic [BW-1:0]     r_sb;
    logic [BW-1:0]     r_n;
    logic [BW-1:0]     r_b;
    logic [KIDX_W-1:0] r_kpos;
    logic [KCNT_W-1:0] r_key_cnt;

    logic [BW-1:0]     r_out;
    logic              r_out_vld;

    logic              rd_en;
    logic [BW-1:0]     rd_addr;
    logic              wr_en;
    logic [BW-1:0]     wr_addr;
    logic [BW-1:0]     wr_data;
    logic [BW-1:0]     perm_q;
    logic [BW-1:0]     idx_a_nxt;
    logic [BW-1:0]     idx_j_nxt;
    logic [BW-1:0]     b_nxt;
    logic [KCNT_W-1:0] kpos_inc;
    logic              out_free;

    // an entry never written since reset or schedule start holds its own index
    assign perm_q    = r_rd_vld ? r_rd_data : r_rd_addr;
    assign idx_a_nxt = BW'(r_idx_i + 8'd1);
    assign idx_j_nxt = BW'(r_idx_j + perm_q);
    assign b_nxt     = BW'(r_b + perm_q + r_key_q);
    assign kpos_inc  = KCNT_W'(r_kpos) + KCNT_W'(1);
    assign out_free  = !r_out_vld || i_ready;

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_n;
        priority if (i_cmd.ks_rd_a) begin
            rd_addr = idx_a_nxt;
        end else if (i_cmd.ks_rd_j) begin
            rd_addr = idx_j_nxt;
        end else if (i_cmd.ks_rd_s) begin
            rd_addr = BW'(r_sa + r_sb);
        end else if (i_cmd.sch_b) begin
            rd_addr = b_nxt;
        end else if (i_cmd.sch_rd) begin
            rd_addr = r_n;
        end else begin
            rd_en = 1'b0;
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx_i;
        wr_data = perm_q;
        priority if (i_cmd.ks_wr_a) begin
            wr_addr = r_idx_i;
            wr_data = perm_q;
        end else if (i_cmd.ks_wr_j) begin
            wr_addr = r_idx_j;
            wr_data = r_sa;
        end else if (i_cmd.sch_wr_n) begin
            wr_addr = r_n;
            wr_data = perm_q;
        end else if (i_cmd.sch_wr_b) begin
            wr_addr = r_b;
            wr_data = r_sa;
        end else begin
            wr_en = 1'b0;
        end
    end

    // permutation memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_perm[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_perm[rd_addr];
            r_rd_vld  <= r_pvld[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= '0;
        end else if (i_cmd.sched_start) begin
            r_pvld <= '0;
        end else if (wr_en) begin
            r_pvld[wr_addr] <= 1'b1;
        end
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load && r_key_cnt < KCNT_MAX) begin
            r_key_mem[r_key_cnt[KIDX_W-1:0]] <= i_key_byte;
        end
        if (i_cmd.sch_rd) begin
            r_key_q <= r_key_mem[r_kpos];
        end
    end

    // indices and schedule counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx_i   <= '0;
            r_idx_j   <= '0;
            r_key_cnt <= '0;
            r_n       <= '0;
            r_b       <= '0;
            r_kpos    <= '0;
        end else begin
            if (i_cmd.key_load && r_key_cnt < KCNT_MAX) begin
                r_key_cnt <= KCNT_W'(r_key_cnt + KCNT_W'(1));
            end
            if (i_cmd.sched_start) begin
                r_n    <= '0;
                r_b    <= '0;
                r_kpos <= '0;
            end
            if (i_cmd.sch_b) begin
                r_b <= b_nxt;
            end
            if (i_cmd.sch_wr_b) begin
                r_n <= BW'(r_n + 8'd1);
                if (kpos_inc >= r_key_cnt) begin
                    r_kpos <= '0;
                end else begin
                    r_kpos <= kpos_inc[KIDX_W-1:0];
                end
                if (r_n == rc4_pkg::PERM_LAST) begin
                    r_idx_i   <= '0;
                    r_idx_j   <= '0;
                    r_key_cnt <= '0;
                end
            end
            if (i_cmd.ks_rd_a) begin
                r_idx_i <= idx_a_nxt;
            end
            if (i_cmd.ks_rd_j) begin
                r_idx_j <= idx_j_nxt;
            end
        end
    end

    // swap operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.ks_rd_j || i_cmd.sch_b) begin
            r_sa <= perm_q;
        end
        if (i_cmd.ks_wr_a) begin
            r_sb <= perm_q;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= perm_q;
        end
    end

    assign o_keystream_byte = r_out;
    assign o_valid          = r_out_vld;
    assign o_sts.sched_last = (r_n == rc4_pkg::PERM_LAST);
    assign o_sts.out_free   = out_free;

    a_key_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_cnt <= KCNT_MAX)
        else $error("key count beyond key store depth");

    a_sched_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sch_wr_b && r_n == rc4_pkg::PERM_LAST)
            |=> (r_idx_i == '0 && r_idx_j == '0 && r_key_cnt == '0 && r_n == '0))
        else $error("indices or key count not cleared at end of key schedule");

    a_kpos_in_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sch_rd |-> (KCNT_W'(r_kpos) < r_key_cnt))
        else $error("key position outside stored key");

endmodule

`default_nettype wire

// ===== rtl/rc4_keystream_generator_core.sv =====
// RC4 keystream generator top level: controller and datapath.
`default_nettype none

// Items with func 0 append a key byte to the key store (bytes beyond the store depth are
// dropped); one carrying key_last then runs the RC4 key schedule and gives no result. Items
// with func 1 return one keystream byte each. A keystream item holds the block until its
// result is loaded (so also through any output stall), in steps set by the single read and
// single write port of the permutation memory: read S[i], read S[j], two swap writes, read
// S[S[i]+S[j]]. The key byte marked last adds the key schedule of 256 steps, each through
// SCH_RD, SCH_B, SCH_WN and SCH_WB, during which no item is taken. Before any key is loaded
// the block uses the identity permutation with both indices zero.
module rc4_keystream_generator_core #(
    parameter int unsigned KEY_STORE_DEPTH = rc4_pkg::KEY_STORE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_func,
    input  wire logic [rc4_pkg::BYTE_W-1:0] i_key_byte,
    input  wire logic                       i_key_last,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [rc4_pkg::BYTE_W-1:0] o_keystream_byte
);

    rc4_pkg::t_dp_cmd cmd;
    rc4_pkg::t_dp_sts sts;

    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_func     (i_func),
        .i_key_last (i_key_last),
        .o_ready    (o_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rc4_dp #(
        .KEY_STORE_DEPTH (KEY_STORE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_key_byte       (i_key_byte),
        .o_keystream_byte (o_keystream_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready)
    );

endmodule

`default_nettype wire

// ===== tb/rc4_keystream_checker.sv =====
// Channel monitor and keystream predictor for the RC4 keystream generator.
`timescale 1ns / 100ps

module rc4_keystream_checker #(
    parameter int unsigned KEY_DEPTH = rc4_pkg::KEY_STORE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_ready,
    input  wire logic                       i_func,
    input  wire logic [rc4_pkg::BYTE_W-1:0] i_key_byte,
    input  wire logic                       i_key_last,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_ready,
    input  wire logic [rc4_pkg::BYTE_W-1:0] i_keystream_byte,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_keys_scheduled,
    output int                              o_long_keys
);

    localparam int MAX_REPORTS = 10;

    logic [rc4_pkg::BYTE_W-1:0] sbox [rc4_pkg::PERM_SIZE];
    logic [rc4_pkg::BYTE_W-1:0] key_mem [KEY_DEPTH];
    int unsigned                key_len;
    int unsigned                key_items;
    logic [rc4_pkg::BYTE_W-1:0] idx_i;
    logic [rc4_pkg::BYTE_W-1:0] idx_j;
    logic [rc4_pkg::BYTE_W-1:0] ks_expected [$];
    logic [rc4_pkg::BYTE_W-1:0] ks_oldest;
    logic [rc4_pkg::BYTE_W-1:0] ks_next;

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_checked        = 0;
        o_keys_scheduled = 0;
        o_long_keys      = 0;
    end

    task automatic swap_sbox(input logic [rc4_pkg::BYTE_W-1:0] x,
                             input logic [rc4_pkg::BYTE_W-1:0] y);
        logic [rc4_pkg::BYTE_W-1:0] t;
        t       = sbox[x];
        sbox[x] = sbox[y];
        sbox[y] = t;
    endtask

    task automatic clear_engine();
        for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) begin
            sbox[n] = n[rc4_pkg::BYTE_W-1:0];
        end
        for (int n = 0; n < KEY_DEPTH; n++) begin
            key_mem[n] = '0;
        end
        key_len   = 0;
        key_items = 0;
        idx_i     = '0;
        idx_j     = '0;
    endtask

    task automatic run_key_schedule();
        int unsigned                len;
        int unsigned                kpos;
        logic [rc4_pkg::BYTE_W-1:0] j;
        len = key_len;
        if (len == 0 || len > KEY_DEPTH) len = 1;
        for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) begin
            sbox[n] = n[rc4_pkg::BYTE_W-1:0];
        end
        j    = '0;
        kpos = 0;
        for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) begin
            j = j + sbox[n] + key_mem[kpos];
            swap_sbox(n[rc4_pkg::BYTE_W-1:0], j);
            kpos++;
            if (kpos >= len) kpos = 0;
        end
        idx_i   = '0;
        idx_j   = '0;
        key_len = 0;
    endtask

    task automatic next_keystream_byte(output logic [rc4_pkg::BYTE_W-1:0] ks);
        logic [rc4_pkg::BYTE_W-1:0] sel;
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        swap_sbox(idx_i, idx_j);
        sel = sbox[idx_i] + sbox[idx_j];
        ks  = sbox[sel];
    endtask

    task automatic note_failure(input string what,
                                input logic [rc4_pkg::BYTE_W-1:0] exp_byte,
                                input logic [rc4_pkg::BYTE_W-1:0] got_byte);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected %02h, got %02h", $realtime, what, exp_byte, got_byte);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_engine();
            ks_expected.delete();
        end else begin
            // results first: nothing accepted at this edge can already have a result
            if (i_out_valid && i_out_ready) begin
                if (ks_expected.size() == 0) begin
                    note_failure("keystream item with none outstanding", 8'h00,
                                 i_keystream_byte);
                end else begin
                    ks_oldest = ks_expected.pop_front();
                    o_checked++;
                    if (i_keystream_byte !== ks_oldest) begin
                        note_failure("keystream byte mismatch", ks_oldest, i_keystream_byte);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_func == rc4_pkg::FUNC_KEYSTREAM) begin
                    next_keystream_byte(ks_next);
                    ks_expected.push_back(ks_next);
                end else begin
                    if (key_len < KEY_DEPTH) begin
                        key_mem[key_len] = i_key_byte;
                        key_len++;
                    end
                    key_items++;
                    if (i_key_last) begin
                        if (key_items > KEY_DEPTH) o_long_keys++;
                        run_key_schedule();
                        o_keys_scheduled++;
                        key_items = 0;
                    end
                end
            end
        end
        o_pending = ks_expected.size();
    end

endmodule

// ===== tb/tb_rc4_keystream_generator_core.sv =====
// Top-level testbench for the RC4 keystream generator: stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tb_rc4_keystream_generator_core;

    localparam int unsigned KEY_DEPTH      = rc4_pkg::KEY_STORE_DEPTH_DEF;
    localparam int unsigned ITEM_TARGET    = 1950;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 1200;
    localparam int unsigned WATCHDOG_LIMIT = 6000;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_valid    = 1'b0;
    logic                       i_func     = rc4_pkg::FUNC_KEY_LOAD;
    logic [rc4_pkg::BYTE_W-1:0] i_key_byte = '0;
    logic                       i_key_last = 1'b0;
    logic                       i_ready    = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic [rc4_pkg::BYTE_W-1:0] o_keystream_byte;

    logic        hold_req  = 1'b0;
    bit          steady    = 1'b0;
    int unsigned items_sent = 0;
    int unsigned idle_cycles = 0;

    int fail_count;
    int ks_pending;
    int bytes_checked;
    int keys_done;
    int long_keys;

    rc4_keystream_generator_core #(
        .KEY_STORE_DEPTH(KEY_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_key_byte      (i_key_byte),
        .i_key_last      (i_key_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_keystream_byte(o_keystream_byte)
    );

    rc4_keystream_checker #(
        .KEY_DEPTH(KEY_DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_func          (i_func),
        .i_key_byte      (i_key_byte),
        .i_key_last      (i_key_last),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_keystream_byte(o_keystream_byte),
        .o_fail_count    (fail_count),
        .o_pending       (ks_pending),
        .o_checked       (bytes_checked),
        .o_keys_scheduled(keys_done),
        .o_long_keys     (long_keys)
    );

    always #6 i_clk = ~i_clk;

    // mostly short gaps, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rc4_pkg::BYTE_W-1:0] pick_key_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return rc4_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic func, input logic [rc4_pkg::BYTE_W-1:0] kbyte,
                             input logic klast);
        int unsigned gap;
        i_valid    <= 1'b1;
        i_func     <= func;
        i_key_byte <= kbyte;
        i_key_last <= klast;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_key(input int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            send_item(rc4_pkg::FUNC_KEY_LOAD, pick_key_byte(), k == len - 1);
        end
    endtask

    // key_byte and key_last carry noise here; the block must ignore them
    task automatic send_requests(input int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            send_item(rc4_pkg::FUNC_KEYSTREAM, rc4_pkg::BYTE_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // receiver: random ready bursts and stalls, plus one long hold-off on request
    initial begin
        int unsigned ready_left;
        int unsigned stall_left;
        bit          hold_taken;
        ready_left = 0;
        stall_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = HOLD_CYCLES;
                ready_left = 0;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (ready_left > 0) begin
                i_ready <= 1'b1;
                ready_left--;
            end else begin
                ready_left = ($urandom_range(0, 99) < 30) ? $urandom_range(20, 100)
                                                          : $urandom_range(1, 8);
                stall_left = pick_gap();
                i_ready <= 1'b1;
                ready_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, ks_pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned sel;
        int unsigned r;
        int unsigned len;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // requests before any key: identity permutation, zero indices
        send_item(rc4_pkg::FUNC_KEYSTREAM, 8'hFF, 1'b1);
        send_item(rc4_pkg::FUNC_KEYSTREAM, 8'h00, 1'b0);
        send_item(rc4_pkg::FUNC_KEYSTREAM, 8'h5A, 1'b1);
        // one-byte key of zero
        send_item(rc4_pkg::FUNC_KEY_LOAD, 8'h00, 1'b1);
        send_requests(2);
        // two-byte key with extreme bytes
        send_item(rc4_pkg::FUNC_KEY_LOAD, 8'hFF, 1'b0);
        send_item(rc4_pkg::FUNC_KEY_LOAD, 8'h01, 1'b1);
        send_requests(3);
        // classic three-byte key "Key"
        send_item(rc4_pkg::FUNC_KEY_LOAD, 8'h4B, 1'b0);
        send_item(rc4_pkg::FUNC_KEY_LOAD, 8'h65, 1'b0);
        send_item(rc4_pkg::FUNC_KEY_LOAD, 8'h79, 1'b1);
        send_requests(4);
        // key bytes split by requests, finished later
        send_item(rc4_pkg::FUNC_KEY_LOAD, 8'hAA, 1'b0);
        send_requests(2);
        send_item(rc4_pkg::FUNC_KEY_LOAD, 8'h55, 1'b1);
        send_requests(1);

        // long receiver hold-off while requests keep coming back to back
        hold_req <= 1'b1;
        steady = 1'b1;
        send_requests(16);
        steady = 1'b0;

        // key that fills the store exactly, then one that overflows it
        send_key(KEY_DEPTH);
        send_requests(8);
        send_key(KEY_DEPTH + 3);
        send_requests(8);

        while (items_sent < ITEM_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                r = $urandom_range(0, 99);
                if (r < 85) len = $urandom_range(1, 16);
                else if (r < 97) len = $urandom_range(17, 64);
                else len = $urandom_range(200, KEY_DEPTH + 40);
                send_key(len);
                send_requests($urandom_range(4, 40));
            end else if (sel < 85) begin
                send_requests($urandom_range(1, 10));
            end else begin
                // unfinished key: bytes stay in the store for the next key
                len = $urandom_range(1, 5);
                for (int unsigned k = 0; k < len; k++) begin
                    send_item(rc4_pkg::FUNC_KEY_LOAD, pick_key_byte(), 1'b0);
                end
                send_requests($urandom_range(1, 6));
            end
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        while (ks_pending != 0) @(posedge i_clk);
        // a trailing key schedule may still be running
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d key schedules (%0d with overlong keys), %0d bytes checked",
                 items_sent, keys_done, long_keys, bytes_checked);
        $display("Receiver held off for %0d cycles once under back-to-back requests; %0d left",
                 HOLD_CYCLES, ks_pending);
        if (fail_count == 0 && ks_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
